FILE: rtl/core/kts_pkg.sv
// Shared types, codes and constants of the keyframe track sampler.
package kts_pkg;

  localparam int unsigned MAX_KEYS_DEF = 64;

  localparam int unsigned KEY_COUNT_W = 7;
  localparam int unsigned KEY_IDX_W   = 6;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST = KEY_COUNT_W'(1);

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BEFORE = 2'd1,
    STAT_PAST   = 2'd2,
    STAT_WRITE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK0,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_e;

  // One stored key: time and the three components.
  typedef struct packed {
    logic [DATA_W-1:0]        t;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } key_t;

  localparam int unsigned KEY_W = $bits(key_t);

endpackage

FILE: rtl/core/kts_if.sv
// Request and result channel interfaces of the keyframe track sampler.
interface kts_req_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     mode;
  logic [kts_pkg::KEY_IDX_W-1:0]            key_index;
  logic [kts_pkg::DATA_W-1:0]               key_time;
  logic signed [kts_pkg::DATA_W-1:0]        key_x;
  logic signed [kts_pkg::DATA_W-1:0]        key_y;
  logic signed [kts_pkg::DATA_W-1:0]        key_z;
  logic [kts_pkg::DATA_W-1:0]               sample_time;

  modport source (
    output valid, mode, key_index, key_time, key_x, key_y, key_z, sample_time,
    input  ready
  );
  modport sink (
    input  valid, mode, key_index, key_time, key_x, key_y, key_z, sample_time,
    output ready
  );
  modport monitor (
    input valid, ready, mode, key_index, key_time, key_x, key_y, key_z, sample_time
  );
endinterface

interface kts_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [kts_pkg::DATA_W-1:0]        out_x;
  logic signed [kts_pkg::DATA_W-1:0]        out_y;
  logic signed [kts_pkg::DATA_W-1:0]        out_z;
  logic [kts_pkg::KEY_IDX_W-1:0]            segment;
  logic [kts_pkg::STATUS_W-1:0]             status;

  modport source (
    output valid, out_x, out_y, out_z, segment, status,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, segment, status,
    output ready
  );
  modport monitor (
    input valid, ready, out_x, out_y, out_z, segment, status
  );
endinterface

FILE: rtl/core/keyframe_track_sampler_unit.sv
// Top level of the keyframe track sampler: key store, search, divide and lerp.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        mode, key_index, key_time, key_x/y/z, sample_time
//   rsp_o    out  valid/ready        out_x/y/z, segment, status
//   cfg      in   cfg_we_i           cfg_wdata_i -> key_count
//
// A write transaction loads the result register at its accept, then goes to the emit step.
// A sample reads key 0, walks the key store one entry per cycle on the RAM read port,
// then runs a restoring divide and a shared multiplier (a multiply step and an add step
// per component); clamped samples finish after the search.
// req_i.ready is high only while idle; a stalled rsp_o holds only the emit step.
// Reset clears control and sets key_count to 1; stored keys stay undefined.
module keyframe_track_sampler_unit #(
  parameter int unsigned MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  kts_req_if.sink                            req_i,
  kts_rsp_if.source                          rsp_o,
  input  logic                               cfg_we_i,
  input  logic [kts_pkg::KEY_COUNT_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_KEYS);
  localparam int unsigned DW    = kts_pkg::DATA_W;
  localparam int unsigned FW    = kts_pkg::FRAC_W;
  localparam int unsigned PW    = DW + 1 + FW + 1;
  localparam int unsigned CNT_W = $clog2(FW);

  kts_pkg::state_e state_q, state_d;

  logic [kts_pkg::KEY_COUNT_W-1:0] key_count_q;
  logic                            out_valid_q;

  // key store
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  kts_pkg::key_t       ram_wdata;
  kts_pkg::key_t       ram_rdata;

  // working registers
  logic [DW-1:0]       t_q;
  logic [IDX_W-1:0]    last_q;
  logic [IDX_W-1:0]    chk_q;
  kts_pkg::key_t       lo_q;
  kts_pkg::key_t       hi_q;
  logic [DW-1:0]       rem_q;
  logic [DW-1:0]       den_q;
  logic [FW-1:0]       quo_q;
  logic [CNT_W-1:0]    div_cnt_q;
  logic [1:0]          comp_q;
  logic signed [PW-1:0] prod_q;

  logic signed [DW-1:0]            res_x_q, res_y_q, res_z_q;
  logic [kts_pkg::KEY_IDX_W-1:0]   res_seg_q;
  logic [kts_pkg::STATUS_W-1:0]    res_stat_q;

  logic signed [DW-1:0]            out_x_q, out_y_q, out_z_q;
  logic [kts_pkg::KEY_IDX_W-1:0]   out_seg_q;
  logic [kts_pkg::STATUS_W-1:0]    out_stat_q;

  logic                 req_fire;
  logic                 emit_go;
  logic [31:0]          kc_ext;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W:0]       nxt_idx;
  logic                 hit;
  logic [DW:0]          rem_sh;
  logic                 rem_ge;
  logic signed [DW-1:0] comp_s, comp_e;
  logic signed [DW:0]   comp_d;
  logic signed [FW:0]   fac;
  logic signed [PW-1:0] prod_d;
  logic signed [DW-1:0] lerp_sum;

  assign req_fire = req_i.valid && req_i.ready;
  assign emit_go  = !out_valid_q || rsp_o.ready;
  assign hit      = t_q < ram_rdata.t;

  // Key count clamped into 1..MAX_KEYS, kept as the last key index.
  always_comb begin
    kc_ext = 32'(key_count_q);
    if (kc_ext == 32'd0) begin
      last_idx = '0;
    end else if (kc_ext > 32'(MAX_KEYS)) begin
      last_idx = IDX_W'(MAX_KEYS - 1);
    end else begin
      last_idx = IDX_W'(kc_ext - 32'd1);
    end
  end

  assign nxt_idx = {1'b0, chk_q} + (IDX_W+1)'(1);

  // Shared restoring divide step.
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  // Shared multiplier for the three components.
  always_comb begin
    unique case (comp_q)
      2'd0:    begin comp_s = lo_q.x; comp_e = hi_q.x; end
      2'd1:    begin comp_s = lo_q.y; comp_e = hi_q.y; end
      default: begin comp_s = lo_q.z; comp_e = hi_q.z; end
    endcase
    comp_d   = {comp_e[DW-1], comp_e} - {comp_s[DW-1], comp_s};
    fac      = {1'b0, quo_q};
    prod_d   = PW'(comp_d * fac);
    // floor of prod / 2^16, wrapped to the field width
    lerp_sum = comp_s + prod_q[FW +: DW];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kts_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.mode == kts_pkg::MODE_WRITE) ? kts_pkg::ST_EMIT
                                                        : kts_pkg::ST_CHECK0;
        end
      end
      kts_pkg::ST_CHECK0: begin
        if (last_q == '0 || hit) begin
          state_d = kts_pkg::ST_EMIT;
        end else begin
          state_d = kts_pkg::ST_SCAN;
        end
      end
      kts_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = kts_pkg::ST_DIV;
        end else if (chk_q == last_q) begin
          state_d = kts_pkg::ST_EMIT;
        end
      end
      kts_pkg::ST_DIV: begin
        if (div_cnt_q == CNT_W'(FW - 1)) begin
          state_d = kts_pkg::ST_MUL;
        end
      end
      kts_pkg::ST_MUL: state_d = kts_pkg::ST_ADD;
      kts_pkg::ST_ADD: begin
        state_d = (comp_q == 2'd2) ? kts_pkg::ST_EMIT : kts_pkg::ST_MUL;
      end
      kts_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_d = kts_pkg::ST_IDLE;
        end
      end
      default: state_d = kts_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = '0;
    unique case (state_q)
      kts_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        ram_we      = req_i.valid && (req_i.mode == kts_pkg::MODE_WRITE) &&
                      (32'(req_i.key_index) < 32'(MAX_KEYS));
      end
      kts_pkg::ST_CHECK0: ram_raddr = IDX_W'(1);
      kts_pkg::ST_SCAN: begin
        if (nxt_idx < (IDX_W+1)'(MAX_KEYS)) begin
          ram_raddr = nxt_idx[IDX_W-1:0];
        end
      end
      default: ram_raddr = '0;
    endcase
  end

  assign ram_waddr   = IDX_W'(req_i.key_index);
  assign ram_wdata.t = req_i.key_time;
  assign ram_wdata.x = req_i.key_x;
  assign ram_wdata.y = req_i.key_y;
  assign ram_wdata.z = req_i.key_z;

  kts_ram #(
    .WIDTH (kts_pkg::KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kts_pkg::ST_IDLE;
      key_count_q <= kts_pkg::KEY_COUNT_RST;
      out_valid_q <= 1'b0;
      chk_q       <= '0;
      div_cnt_q   <= '0;
      comp_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
      if (state_q == kts_pkg::ST_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        kts_pkg::ST_CHECK0: chk_q <= IDX_W'(1);
        kts_pkg::ST_SCAN: begin
          if (!hit && chk_q != last_q) begin
            chk_q <= chk_q + IDX_W'(1);
          end
          div_cnt_q <= '0;
          comp_q    <= '0;
        end
        kts_pkg::ST_DIV: div_cnt_q <= div_cnt_q + CNT_W'(1);
        kts_pkg::ST_ADD: comp_q <= comp_q + 2'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      kts_pkg::ST_IDLE: begin
        if (req_fire) begin
          t_q        <= req_i.sample_time;
          last_q     <= last_idx;
          res_x_q    <= '0;
          res_y_q    <= '0;
          res_z_q    <= '0;
          res_seg_q  <= req_i.key_index;
          res_stat_q <= kts_pkg::STAT_WRITE;
        end
      end
      kts_pkg::ST_CHECK0: begin
        lo_q       <= ram_rdata;
        res_x_q    <= ram_rdata.x;
        res_y_q    <= ram_rdata.y;
        res_z_q    <= ram_rdata.z;
        res_seg_q  <= '0;
        res_stat_q <= (last_q != '0 && hit) ? kts_pkg::STAT_BEFORE : kts_pkg::STAT_OK;
      end
      kts_pkg::ST_SCAN: begin
        res_seg_q <= kts_pkg::KEY_IDX_W'(chk_q - IDX_W'(1));
        if (hit) begin
          hi_q  <= ram_rdata;
          rem_q <= t_q - lo_q.t;
          den_q <= ram_rdata.t - lo_q.t;
          res_stat_q <= kts_pkg::STAT_OK;
        end else begin
          lo_q       <= ram_rdata;
          res_x_q    <= ram_rdata.x;
          res_y_q    <= ram_rdata.y;
          res_z_q    <= ram_rdata.z;
          res_stat_q <= kts_pkg::STAT_PAST;
        end
      end
      kts_pkg::ST_DIV: begin
        rem_q <= rem_ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
        quo_q <= {quo_q[FW-2:0], rem_ge};
      end
      kts_pkg::ST_MUL: prod_q <= prod_d;
      kts_pkg::ST_ADD: begin
        unique case (comp_q)
          2'd0:    res_x_q <= lerp_sum;
          2'd1:    res_y_q <= lerp_sum;
          default: res_z_q <= lerp_sum;
        endcase
      end
      kts_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_x_q    <= res_x_q;
          out_y_q    <= res_y_q;
          out_z_q    <= res_z_q;
          out_seg_q  <= res_seg_q;
          out_stat_q <= res_stat_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.out_x   = out_x_q;
  assign rsp_o.out_y   = out_y_q;
  assign rsp_o.out_z   = out_z_q;
  assign rsp_o.segment = out_seg_q;
  assign rsp_o.status  = out_stat_q;

endmodule

FILE: rtl/core/kts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
  parameter int unsigned WIDTH = kts_pkg::KEY_W,
  parameter int unsigned DEPTH = kts_pkg::MAX_KEYS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/kts_checker.sv
// Port-level assertions for the keyframe track sampler, bound to the top level.
module kts_checker (
  input logic         clk_i,
  input logic         rst_ni,
  kts_req_if.sink     req_i,
  kts_rsp_if.source   rsp_o
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.out_x) &&
      $stable(rsp_o.out_y) && $stable(rsp_o.out_z) && $stable(rsp_o.segment) &&
      $stable(rsp_o.status))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while busy");

  // write acknowledgments carry zero components
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == kts_pkg::STAT_WRITE |->
      rsp_o.out_x == '0 && rsp_o.out_y == '0 && rsp_o.out_z == '0)
    else $error("write acknowledgment with nonzero data");

  // clamp before the first key always reports segment zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == kts_pkg::STAT_BEFORE |-> rsp_o.segment == '0)
    else $error("before-first-key result with nonzero segment");

endmodule

bind keyframe_track_sampler_unit kts_checker u_kts_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

FILE: sim/tb_keyframe_track_sampler_unit.sv
// Self-checking testbench for keyframe_track_sampler_unit: key writes, samples and key_count.
module tb_keyframe_track_sampler_unit;

  localparam int unsigned RUN_LIMIT = 500000;

  typedef struct {
    kts_pkg::mode_e                    mode;
    logic [kts_pkg::KEY_IDX_W-1:0]     key_index;
    logic [kts_pkg::DATA_W-1:0]        key_time;
    logic [kts_pkg::DATA_W-1:0]        key_x;
    logic [kts_pkg::DATA_W-1:0]        key_y;
    logic [kts_pkg::DATA_W-1:0]        key_z;
    logic [kts_pkg::DATA_W-1:0]        sample_time;
  } req_item_t;

  typedef struct {
    logic [kts_pkg::DATA_W-1:0]        x;
    logic [kts_pkg::DATA_W-1:0]        y;
    logic [kts_pkg::DATA_W-1:0]        z;
    logic [kts_pkg::KEY_IDX_W-1:0]     seg;
    kts_pkg::status_e                  st;
    longint unsigned                   accepted_at;
  } resp_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [kts_pkg::KEY_COUNT_W-1:0] cfg_wdata_i;

  kts_req_if req_if ();
  kts_rsp_if rsp_if ();

  keyframe_track_sampler_unit #(
    .MAX_KEYS(kts_pkg::MAX_KEYS_DEF)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Track mirror used for expected results
  logic [kts_pkg::DATA_W-1:0]      key_time_q [kts_pkg::MAX_KEYS_DEF];
  logic [kts_pkg::DATA_W-1:0]      key_x_q    [kts_pkg::MAX_KEYS_DEF];
  logic [kts_pkg::DATA_W-1:0]      key_y_q    [kts_pkg::MAX_KEYS_DEF];
  logic [kts_pkg::DATA_W-1:0]      key_z_q    [kts_pkg::MAX_KEYS_DEF];
  logic [kts_pkg::KEY_COUNT_W-1:0] track_len;

  // Key times as queued by the stimulus, used only to aim sample times
  logic [kts_pkg::DATA_W-1:0]      plan_time  [kts_pkg::MAX_KEYS_DEF];

  req_item_t  queued_requests[$];
  resp_item_t pending_responses[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rsp_hold_cycles = 0;
  bit          steady_flow = 1'b0;

  function automatic logic [kts_pkg::DATA_W-1:0] lerp_q16(logic [kts_pkg::DATA_W-1:0] a,
                                                          logic [kts_pkg::DATA_W-1:0] b,
                                                          logic [16:0] f);
    longint s;
    longint d;
    longint p;
    s = longint'(signed'(a));
    d = longint'(signed'(b)) - s;
    p = d * longint'(f);
    // >>> on a signed value floors toward minus infinity
    return kts_pkg::DATA_W'(s + (p >>> kts_pkg::FRAC_W));
  endfunction

  function automatic resp_item_t track_response(req_item_t it);
    resp_item_t  r;
    int unsigned n;
    int unsigned seg;
    int unsigned lo_k;
    int unsigned i;
    bit          at_key;
    logic [47:0] quo;
    logic [31:0] span;
    logic [16:0] f;
    r.accepted_at = 0;
    if (it.mode == kts_pkg::MODE_WRITE) begin
      key_time_q[it.key_index] = it.key_time;
      key_x_q[it.key_index]    = it.key_x;
      key_y_q[it.key_index]    = it.key_y;
      key_z_q[it.key_index]    = it.key_z;
      r.x   = '0;
      r.y   = '0;
      r.z   = '0;
      r.seg = it.key_index;
      r.st  = kts_pkg::STAT_WRITE;
      return r;
    end
    n = 32'(track_len);
    if (n == 0) n = 1;
    if (n > kts_pkg::MAX_KEYS_DEF) n = kts_pkg::MAX_KEYS_DEF;
    r.st   = kts_pkg::STAT_OK;
    seg    = 0;
    lo_k   = 0;
    at_key = 1'b1;
    if (n == 1) begin
      r.st = kts_pkg::STAT_OK;
    end else if (it.sample_time < key_time_q[0]) begin
      r.st = kts_pkg::STAT_BEFORE;
    end else begin
      seg = n;
      for (i = 0; i + 1 < n; i++) begin
        if (seg == n && it.sample_time < key_time_q[i+1]) seg = i;
      end
      if (seg == n) begin
        lo_k = n - 1;
        seg  = n - 2;
        r.st = kts_pkg::STAT_PAST;
      end else begin
        at_key = 1'b0;
      end
    end
    r.seg = kts_pkg::KEY_IDX_W'(seg);
    if (at_key) begin
      r.x = key_x_q[lo_k];
      r.y = key_y_q[lo_k];
      r.z = key_z_q[lo_k];
      return r;
    end
    span = key_time_q[seg+1] - key_time_q[seg];
    quo  = (span != 0) ? {it.sample_time - key_time_q[seg], 16'h0000} / {16'h0000, span} : '0;
    f    = (quo > 48'd65535) ? 17'd65535 : quo[16:0];
    r.x  = lerp_q16(key_x_q[seg], key_x_q[seg+1], f);
    r.y  = lerp_q16(key_y_q[seg], key_y_q[seg+1], f);
    r.z  = lerp_q16(key_z_q[seg], key_z_q[seg+1], f);
    return r;
  endfunction

  // Request driver: predicts each accepted transaction, then offers the next one
  req_item_t   in_flight;
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    resp_item_t want;
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.mode        <= kts_pkg::MODE_WRITE;
      req_if.key_index   <= '0;
      req_if.key_time    <= '0;
      req_if.key_x       <= '0;
      req_if.key_y       <= '0;
      req_if.key_z       <= '0;
      req_if.sample_time <= '0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        want = track_response(in_flight);
        want.accepted_at = $time;
        pending_responses = {pending_responses, want};
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          in_flight = queued_requests.pop_front();
          req_if.mode        <= in_flight.mode;
          req_if.key_index   <= in_flight.key_index;
          req_if.key_time    <= in_flight.key_time;
          req_if.key_x       <= in_flight.key_x;
          req_if.key_y       <= in_flight.key_y;
          req_if.key_z       <= in_flight.key_z;
          req_if.sample_time <= in_flight.sample_time;
          req_if.valid       <= 1'b1;
          if (!steady_flow && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready: long hold when requested, otherwise short random stalls
  int unsigned rsp_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
    end else if (rsp_hold_cycles != 0) begin
      rsp_hold_cycles--;
      rsp_if.ready <= 1'b0;
    end else if (rsp_stall != 0) begin
      rsp_stall--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 9);
    end
  end

  task automatic check_field(input string name, input logic [kts_pkg::DATA_W-1:0] want,
                             input logic [kts_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%h, actual 0x%h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    resp_item_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      // an expectation stamped this edge cannot have produced a result yet
      if (pending_responses.size() == 0 || pending_responses[0].accepted_at >= $time) begin
        $error("result transaction with no expected result waiting");
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("out_x", want.x, rsp_if.out_x);
        check_field("out_y", want.y, rsp_if.out_y);
        check_field("out_z", want.z, rsp_if.out_z);
        check_field("segment", kts_pkg::DATA_W'(want.seg), kts_pkg::DATA_W'(rsp_if.segment));
        check_field("status", kts_pkg::DATA_W'(want.st), kts_pkg::DATA_W'(rsp_if.status));
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("keyframe_track_sampler_unit test failed");
    $finish;
  end

  function automatic logic [kts_pkg::DATA_W-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_write(input logic [kts_pkg::KEY_IDX_W-1:0] idx,
                             input logic [kts_pkg::DATA_W-1:0] t,
                             input logic [kts_pkg::DATA_W-1:0] x, y, z);
    req_item_t it;
    it.mode        = kts_pkg::MODE_WRITE;
    it.key_index   = idx;
    it.key_time    = t;
    it.key_x       = x;
    it.key_y       = y;
    it.key_z       = z;
    it.sample_time = $urandom;
    plan_time[idx] = t;
    queued_requests = {queued_requests, it};
  endtask

  task automatic queue_sample(input logic [kts_pkg::DATA_W-1:0] t);
    req_item_t it;
    it.mode        = kts_pkg::MODE_SAMPLE;
    it.key_index   = kts_pkg::KEY_IDX_W'($urandom);
    it.key_time    = $urandom;
    it.key_x       = $urandom;
    it.key_y       = $urandom;
    it.key_z       = $urandom;
    it.sample_time = t;
    queued_requests = {queued_requests, it};
  endtask

  // Writes keys 0..n-1 with non-decreasing times, now and then one out of order
  task automatic load_track(input int unsigned n);
    logic [32:0] at;
    logic [31:0] step_max;
    int unsigned k;
    at = ($urandom_range(0, 3) == 0) ? 33'd0 : {1'b0, $urandom};
    step_max = 32'((33'h0_FFFF_FFFF - at) / n);
    if ($urandom_range(0, 2) == 0 && step_max > 32'h0004_0000) step_max = 32'h0004_0000;
    for (k = 0; k < n; k++) begin
      queue_write(kts_pkg::KEY_IDX_W'(k), at[31:0], rand_comp(), rand_comp(), rand_comp());
      at += 33'($urandom_range(0, step_max));
    end
    if ($urandom_range(0, 5) == 0) begin
      queue_write(kts_pkg::KEY_IDX_W'($urandom_range(0, n - 1)), $urandom, rand_comp(),
                  rand_comp(), rand_comp());
    end
  endtask

  task automatic sample_track(input int unsigned n, input int unsigned count);
    int unsigned j;
    int unsigned k;
    logic [31:0] t;
    for (j = 0; j < count; j++) begin
      if ($urandom_range(0, 15) == 0) begin
        queue_write(kts_pkg::KEY_IDX_W'($urandom_range(0, 63)), $urandom, rand_comp(),
                    rand_comp(), rand_comp());
      end else begin
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
          0: t = $urandom;
          1: t = (plan_time[0] == 0) ? 32'd0 : $urandom_range(0, plan_time[0] - 1);
          2: t = plan_time[n-1] + $urandom_range(0, ~plan_time[n-1]);
          3: t = plan_time[k];
          default: begin
            if (k + 1 < n && plan_time[k+1] > plan_time[k])
              t = plan_time[k] + $urandom_range(0, plan_time[k+1] - plan_time[k] - 1);
            else
              t = $urandom;
          end
        endcase
        queue_sample(t);
      end
    end
  endtask

  // Wait for every queued transaction and its result, then for the extra cycles requested
  task automatic settle(input int unsigned extra);
    @(negedge clk_i);
    while (queued_requests.size() != 0 || req_if.valid || pending_responses.size() != 0)
      @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_key_count(input logic [kts_pkg::KEY_COUNT_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    track_len = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [kts_pkg::KEY_COUNT_W-1:0] c;
    int unsigned n;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    track_len          = kts_pkg::KEY_COUNT_RST;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single key, using the count left by reset
    queue_write(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    queue_sample(32'h0000_0000);
    queue_sample(32'hFFFF_FFFF);
    settle(8);
    write_key_count(7'd0);
    queue_sample(32'h1234_5678);
    // duplicate time on keys 1 and 2, key 3 at the top of the time range
    queue_write(6'd1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_write(6'd2, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    queue_write(6'd3, 32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678, 32'h8000_0000);
    queue_write(6'd4, 32'h0000_8000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
    settle(8);
    write_key_count(7'd4);
    queue_sample(32'h0000_0000);
    queue_sample(32'h0000_FFFF);
    queue_sample(32'h0001_0000);
    queue_sample(32'h0002_0000);
    queue_sample(32'h0002_FFFF);
    queue_sample(32'h0003_0000);
    queue_sample(32'h8000_0000);
    queue_sample(32'hFFFF_FFFE);
    queue_sample(32'hFFFF_FFFF);
    settle(8);
    // last key earlier than the one before it
    write_key_count(7'd5);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h0002_0000);
    queue_sample(32'h0004_0000);

    settle(8);
    write_key_count(7'd64);
    load_track(64);
    sample_track(64, 40);

    settle(8);
    write_key_count(7'd127);
    load_track(64);
    sample_track(64, 30);
    settle(8);
    sample_track(64, 30);

    // long response hold while requests keep coming
    settle(8);
    write_key_count(7'd2);
    load_track(2);
    rsp_hold_cycles = 400;
    sample_track(2, 80);

    settle(8);
    write_key_count(7'd65);
    load_track(64);
    sample_track(64, 60);

    settle(8);
    write_key_count(7'd1);
    load_track(1);
    sample_track(1, 40);

    settle(8);
    write_key_count(7'd0);
    load_track(1);
    sample_track(1, 40);

    settle(8);
    write_key_count(7'd3);
    load_track(3);
    sample_track(3, 80);

    settle(8);
    write_key_count(7'd33);
    load_track(33);
    sample_track(33, 60);

    repeat (2) begin
      c = kts_pkg::KEY_COUNT_W'($urandom_range(0, 127));
      n = (c == 0) ? 1 : ((c > kts_pkg::MAX_KEYS_DEF) ? kts_pkg::MAX_KEYS_DEF : 32'(c));
      settle(8);
      write_key_count(c);
      load_track(n);
      sample_track(n, 50);
    end

    settle(8);
    steady_flow = 1'b1;
    write_key_count(7'd8);
    load_track(8);
    sample_track(8, 60);

    settle(100);
    if (fail_count == 0 && pending_responses.size() == 0) begin
      $display("keyframe_track_sampler_unit test passed");
    end else begin
      $display("keyframe_track_sampler_unit test failed");
    end
    $finish;
  end

endmodule
